@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define LOBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("order book check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define LOBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("order book check failed");

`endif

@@ design/lobt_pkg.sv @@
`default_nettype none
package lobt_pkg;
    localparam int unsigned InstrumentsDefault = 4;
    localparam int unsigned LevelsDefault      = 64;
    localparam int unsigned TopLevelsDefault   = 20;

    localparam int unsigned InstW  = 2;
    localparam int unsigned ValW   = 48;
    localparam int unsigned RankW  = 5;
    localparam int unsigned SDataW = 104;
    localparam int unsigned MDataW = 112;

    localparam logic CmdUpdate = 1'b0;
    localparam logic CmdClear  = 1'b1;
    localparam logic SideAsk   = 1'b0;
    localparam logic SideBid   = 1'b1;
endpackage
`default_nettype wire

@@ design/limit_order_book_top_levels_top.sv @@
`default_nettype none
// Channel   Dir  tdata (low bit first)                                  tuser  tlast
// s_        in   instrument, side, price, volume                        cmd    end_of_message
// m_        out  book_instrument, level_side, level_rank, level_price,  none   last
//                level_volume, level_valid
// One item at a time. The search reads and compares one stored level after another, and each
// level moved by an insert or a delete is first read, then written at its new place.
// Reset clears the fill counts, state and output valid; no RAM clearing pass is needed.
// A stalled m_ side holds the snapshot sequencer; s_tready stays low until its last beat is
// loaded into the output register.
`include "assert_macros.svh"
module limit_order_book_top_levels_top #(
    parameter int unsigned INSTRUMENTS     = lobt_pkg::InstrumentsDefault,
    parameter int unsigned LEVELS_PER_SIDE = lobt_pkg::LevelsDefault,
    parameter int unsigned TOP_LEVELS      = lobt_pkg::TopLevelsDefault
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // instrument[1:0], side[2], price[50:3], volume[98:51], zero fill
    input  wire logic [lobt_pkg::SDataW-1:0] s_tdata,
    // cmd[0]
    input  wire logic                       s_tuser,
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // book_instrument[1:0], level_side[2], level_rank[7:3], level_price[55:8],
    // level_volume[103:56], level_valid[104], zero fill
    output logic [lobt_pkg::MDataW-1:0]     m_tdata,
    output logic                            m_tlast
);
    localparam int unsigned VW  = lobt_pkg::ValW;
    localparam int unsigned IW  = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int unsigned LW  = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;
    localparam int unsigned FW  = $clog2(LEVELS_PER_SIDE + 1);
    localparam int unsigned AW  = 1 + lobt_pkg::InstW + LW;
    localparam int unsigned RCW = (2 * TOP_LEVELS > 1) ? $clog2(2 * TOP_LEVELS) : 1;
    localparam int unsigned EW  = 2 * VW;

    localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCMP = 4'd2, S_DECIDE = 4'd3,
                           S_MRD = 4'd4, S_MWR = 4'd5, S_FIN = 4'd6, S_NRD = 4'd7,
                           S_NOUT = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [FW-1:0] ask_fill_reg [INSTRUMENTS], ask_fill_next [INSTRUMENTS];
    logic [FW-1:0] bid_fill_reg [INSTRUMENTS], bid_fill_next [INSTRUMENTS];
    logic [lobt_pkg::InstW-1:0] inst_reg, inst_next;
    logic          side_reg, side_next, eom_reg, eom_next;
    logic [VW-1:0] price_reg, price_next, vol_reg, vol_next;
    logic [FW-1:0] i_reg, i_next, n_reg, n_next, k_reg, k_next;
    logic          found_reg, found_next, del_reg, del_next, sval_reg, sval_next;
    logic [RCW-1:0] r_reg, r_next;
    logic          m_tvalid_reg, m_tvalid_next, m_tlast_reg, m_tlast_next;
    logic [lobt_pkg::MDataW-1:0] m_tdata_reg, m_tdata_next;

    logic [EW-1:0] mem [2 ** AW];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    logic [lobt_pkg::InstW-1:0] in_inst;
    logic [IW-1:0] in_idx, cur_idx;
    logic [VW-1:0] rd_price;
    logic          better, snap_side, out_free;
    logic [lobt_pkg::RankW-1:0] snap_rank;
    logic [FW-1:0] snap_fill;

    assign in_inst  = s_tdata[1:0];
    assign in_idx   = IW'(in_inst);
    assign cur_idx  = IW'(inst_reg);
    assign rd_price = rdata_reg[EW-1:VW];
    assign better   = side_reg ? (rd_price > price_reg) : (rd_price < price_reg);
    assign snap_side = (32'(r_reg) >= TOP_LEVELS);
    assign snap_rank = snap_side ? lobt_pkg::RankW'(32'(r_reg) - TOP_LEVELS)
                                 : lobt_pkg::RankW'(r_reg);
    assign snap_fill = snap_side ? bid_fill_reg[cur_idx] : ask_fill_reg[cur_idx];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        state_next    = state_reg;
        ask_fill_next = ask_fill_reg;
        bid_fill_next = bid_fill_reg;
        inst_next     = inst_reg;
        side_next     = side_reg;
        eom_next      = eom_reg;
        price_next    = price_reg;
        vol_next      = vol_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        found_next    = found_reg;
        del_next      = del_reg;
        sval_next     = sval_reg;
        r_next        = r_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        waddr         = {side_reg, inst_reg, LW'(k_reg)};
        wdata         = rdata_reg;
        raddr         = {side_reg, inst_reg, LW'(i_reg)};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == lobt_pkg::CmdClear) begin
                        for (int j = 0; j < INSTRUMENTS; j++) begin
                            ask_fill_next[j] = '0;
                            bid_fill_next[j] = '0;
                        end
                    end else if (32'(in_inst) < INSTRUMENTS) begin
                        inst_next  = in_inst;
                        side_next  = s_tdata[2];
                        price_next = s_tdata[50:3];
                        vol_next   = s_tdata[98:51];
                        eom_next   = s_tlast;
                        n_next     = (s_tdata[2] == lobt_pkg::SideBid) ? bid_fill_reg[in_idx]
                                                                      : ask_fill_reg[in_idx];
                        i_next     = '0;
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (i_reg < n_reg) begin
                    state_next = S_SCMP;
                end else begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_SCMP: begin
                if (better) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SRD;
                end else begin
                    found_next = (rd_price == price_reg);
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_FIN;
                k_next     = i_reg;
                if (found_reg) begin
                    if (vol_reg == '0) begin
                        del_next   = 1'b1;
                        state_next = S_MRD;
                        if (side_reg) bid_fill_next[cur_idx] = n_reg - 1'b1;
                        else          ask_fill_next[cur_idx] = n_reg - 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        waddr  = {side_reg, inst_reg, LW'(i_reg)};
                        wdata  = {price_reg, vol_reg};
                    end
                end else if (vol_reg != '0 &&
                             !(32'(n_reg) == LEVELS_PER_SIDE && i_reg >= n_reg)) begin
                    // A full side drops its worst level to make room.
                    if (32'(n_reg) == LEVELS_PER_SIDE) begin
                        k_next = n_reg - 1'b1;
                        if (side_reg) bid_fill_next[cur_idx] = n_reg;
                        else          ask_fill_next[cur_idx] = n_reg;
                    end else begin
                        k_next = n_reg;
                        if (side_reg) bid_fill_next[cur_idx] = n_reg + 1'b1;
                        else          ask_fill_next[cur_idx] = n_reg + 1'b1;
                    end
                    del_next   = 1'b0;
                    state_next = S_MRD;
                end
            end
            S_MRD: begin
                if (del_reg) begin
                    raddr = {side_reg, inst_reg, LW'(k_reg + 1'b1)};
                    state_next = ((FW + 1)'(k_reg) + 1'b1 < (FW + 1)'(n_reg)) ? S_MWR : S_FIN;
                end else begin
                    raddr = {side_reg, inst_reg, LW'(k_reg - 1'b1)};
                    if (k_reg > i_reg) begin
                        state_next = S_MWR;
                    end else begin
                        mem_we     = 1'b1;
                        waddr      = {side_reg, inst_reg, LW'(i_reg)};
                        wdata      = {price_reg, vol_reg};
                        state_next = S_FIN;
                    end
                end
            end
            S_MWR: begin
                mem_we     = 1'b1;
                k_next     = del_reg ? k_reg + 1'b1 : k_reg - 1'b1;
                state_next = S_MRD;
            end
            S_FIN: begin
                r_next     = '0;
                state_next = eom_reg ? S_NRD : S_IDLE;
            end
            S_NRD: begin
                raddr      = {snap_side, inst_reg, LW'(snap_rank)};
                sval_next  = (32'(snap_rank) < 32'(snap_fill));
                state_next = S_NOUT;
            end
            S_NOUT: begin
                // Keep reading the same level so the data survives a stalled output.
                raddr = {snap_side, inst_reg, LW'(snap_rank)};
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (32'(r_reg) == 2 * TOP_LEVELS - 1);
                    m_tdata_next  = '0;
                    m_tdata_next[1:0]    = inst_reg;
                    m_tdata_next[2]      = snap_side;
                    m_tdata_next[7:3]    = snap_rank;
                    m_tdata_next[55:8]   = sval_reg ? rd_price : '0;
                    m_tdata_next[103:56] = sval_reg ? rdata_reg[VW-1:0] : '0;
                    m_tdata_next[104]    = sval_reg;
                    if (32'(r_reg) == 2 * TOP_LEVELS - 1) begin
                        state_next = S_IDLE;
                    end else begin
                        r_next     = r_reg + 1'b1;
                        state_next = S_NRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int j = 0; j < INSTRUMENTS; j++) begin
                ask_fill_reg[j] <= '0;
                bid_fill_reg[j] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            ask_fill_reg  <= ask_fill_next;
            bid_fill_reg  <= bid_fill_next;
        end
        inst_reg    <= inst_next;
        side_reg    <= side_next;
        eom_reg     <= eom_next;
        price_reg   <= price_next;
        vol_reg     <= vol_next;
        i_reg       <= i_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        found_reg   <= found_next;
        del_reg     <= del_next;
        sval_reg    <= sval_next;
        r_reg       <= r_next;
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

    `LOBT_ASSERT_NOW(a_idle_no_write, state_reg == S_IDLE, !mem_we)
    `LOBT_ASSERT_NOW(a_last_is_bid, m_tvalid && m_tlast, m_tdata[2] == lobt_pkg::SideBid)
    `LOBT_ASSERT_NOW(a_search_bound, state_reg == S_SCMP, i_reg < n_reg)
    `LOBT_ASSERT_NEXT(a_last_frees_input,
        m_tvalid_next && m_tlast_next && out_free && state_reg == S_NOUT, s_tready)
endmodule
`default_nettype wire
